@@ rtl/core/assert_macros.svh @@
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PRD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/prd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package prd_pkg;

  localparam int MAX_RUNWAYS = 16;
  localparam int QUEUE_DEPTH = 256;
  localparam int RW_W = $clog2(MAX_RUNWAYS);
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = QA_W + 1;
  localparam int POS_W = 6;
  localparam int N_POS = 1 + 2 * MAX_RUNWAYS;
  localparam logic [15:0] LANDING_BASE = 16'd5000;

  localparam logic [1:0] CFG_LANDING_TIME = 2'd0;
  localparam logic [1:0] CFG_TAKEOFF_TIME = 2'd1;
  localparam logic [1:0] CFG_SERVERS = 2'd2;

  localparam logic [1:0] EV_HEADER = 2'd0;
  localparam logic [1:0] EV_FREE = 2'd1;
  localparam logic [1:0] EV_LAND = 2'd2;
  localparam logic [1:0] EV_TAKEOFF = 2'd3;

  typedef struct packed {
    logic [3:0] new_landings;
    logic [3:0] new_takeoffs;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  runway;
    logic [15:0] plane_id;
    logic [31:0] tick;
    logic [31:0] land_wait_sum;
    logic [31:0] takeoff_wait_sum;
    logic [31:0] land_arrivals;
    logic [31:0] takeoff_arrivals;
    logic [31:0] busy_total;
    logic        all_idle;
    logic        overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic            push_l;
    logic            push_t;
    logic            rd;
    logic            asg;
    logic            load;
    logic            done;
    logic [RW_W-1:0] idx;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [4:0] used;
    logic [3:0] nl;
    logic [3:0] nt;
    logic       ev_here;
    logic       out_room;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/priority_runway_dispatcher_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Strict-priority runway dispatcher. One input item is one tick; it yields a header item, then
// one item per freed runway and one per assignment, in runway order, all carrying end-of-tick
// totals, with last set on the final one. The queues take one push per cycle, each runway takes a
// head-read state and then an assign state because the queue head read is registered, and the
// result walk visits all 33 event slots one per cycle while the output is not stalled. Configure
// only between ticks.
module priority_runway_dispatcher_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  prd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_stall,
  output prd_pkg::out_item_t out_item,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_idx,
  input  wire [7:0]          cfg_wdata
);
  import prd_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  prd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  prd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `PRD_ASSERT(a_one_cmd, $onehot0({cmd.start, cmd.push_l, cmd.push_t, cmd.rd, cmd.asg, cmd.load, cmd.done}), "more than one command")
  `PRD_ASSERT_IMPL(a_asg_after_rd, cmd.asg, $past(cmd.rd), "assign without head read")
  `PRD_ASSERT_IMPL(a_load_room, cmd.load, sts.out_room, "output overwritten")

endmodule
`default_nettype wire

@@ rtl/core/prd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module prd_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  prd_pkg::sts_t  sts,
  output prd_pkg::cmd_t  cmd
);
  import prd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PUSHL = 6'b000010,
    S_PUSHT = 6'b000100,
    S_ARD   = 6'b001000,
    S_AEX   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    cmd = '0;
    cmd.idx = cnt_r[RW_W-1:0];
    cmd.pos = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_PUSHL;
        end
      end
      S_PUSHL: begin
        if (cnt_r >= {1'b0, sts.nl}) begin
          cnt_nxt = '0;
          state_nxt = S_PUSHT;
        end else begin
          cmd.push_l = 1'b1;
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_PUSHT: begin
        if (cnt_r >= {1'b0, sts.nt}) begin
          cnt_nxt = '0;
          state_nxt = S_ARD;
        end else begin
          cmd.push_t = 1'b1;
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_ARD: begin
        if (cnt_r >= sts.used) begin
          pos_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_AEX;
        end
      end
      S_AEX: begin
        cmd.asg = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        state_nxt = S_ARD;
      end
      S_EMIT: begin
        if (pos_r == POS_W'(N_POS)) begin
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end else if (!sts.ev_here) begin
          pos_nxt = pos_r + 1'b1;
        end else if (sts.out_room) begin
          cmd.load = 1'b1;
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/prd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module prd_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  prd_pkg::in_item_t  in_item,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_idx,
  input  wire [7:0]          cfg_wdata,
  input  prd_pkg::cmd_t      cmd,
  output prd_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire                out_stall,
  output prd_pkg::out_item_t out_item
);
  import prd_pkg::*;

  logic [7:0] land_time_r, take_time_r;
  logic [4:0] servers_r, used;
  logic [3:0] nl_r, nt_r;

  logic [15:0] lq_mem [QUEUE_DEPTH];
  logic [15:0] tq_mem [QUEUE_DEPTH];
  logic [QA_W-1:0] lq_head_r, tq_head_r;
  logic [QC_W-1:0] lq_cnt_r, tq_cnt_r;
  logic [15:0] lq_rd_r, tq_rd_r;
  logic [15:0] lid_r, tid_r, lid_inc, tid_inc;
  logic [QA_W-1:0] lq_tail, tq_tail;
  logic lq_wr, tq_wr;

  logic [7:0] timer_r [MAX_RUNWAYS];
  logic [MAX_RUNWAYS-1:0] pend_r, free_m_r, asg_m_r, asg_tk_r;
  logic [15:0] asg_pid_r [MAX_RUNWAYS];
  logic [31:0] tick_r, lws_r, tws_r, lar_r, tar_r, busy_r;
  logic ovf_r;

  logic [7:0] ld_land, ld_take, tcur, tdec;
  logic [N_POS-1:0] ev;
  logic [POS_W-1:0] pos_nx;
  logic [RW_W-1:0] fidx, aidx;
  logic idle;

  assign used = (servers_r > 5'(MAX_RUNWAYS)) ? 5'(MAX_RUNWAYS) : servers_r;
  assign ld_land = (land_time_r == 8'd0) ? 8'd0 : land_time_r - 8'd1;
  assign ld_take = (take_time_r == 8'd0) ? 8'd0 : take_time_r - 8'd1;
  assign lid_inc = lid_r + 16'd1;
  assign tid_inc = tid_r + 16'd1;
  assign lq_tail = lq_head_r + lq_cnt_r[QA_W-1:0];
  assign tq_tail = tq_head_r + tq_cnt_r[QA_W-1:0];
  assign lq_wr = cmd.push_l && (lq_cnt_r < QC_W'(QUEUE_DEPTH));
  assign tq_wr = cmd.push_t && (tq_cnt_r < QC_W'(QUEUE_DEPTH));
  assign tcur = timer_r[cmd.idx];
  assign tdec = tcur - 8'd1;

  assign ev = {asg_m_r, free_m_r, 1'b1};
  assign pos_nx = cmd.pos + 1'b1;
  assign fidx = RW_W'(cmd.pos - POS_W'(1));
  assign aidx = RW_W'(cmd.pos - POS_W'(1 + MAX_RUNWAYS));

  always_comb begin
    idle = (lq_cnt_r == '0) && (tq_cnt_r == '0);
    for (int i = 0; i < MAX_RUNWAYS; i++) begin
      if ((5'(i) < used) && (timer_r[i] != 8'd0)) idle = 1'b0;
    end
  end

  assign sts.used = used;
  assign sts.nl = nl_r;
  assign sts.nt = nt_r;
  assign sts.ev_here = (cmd.pos < POS_W'(N_POS)) ? ev[cmd.pos] : 1'b0;
  assign sts.out_room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (lq_wr) lq_mem[lq_tail] <= lid_inc;
    if (tq_wr) tq_mem[tq_tail] <= tid_inc;
    if (cmd.rd) begin
      lq_rd_r <= lq_mem[lq_head_r];
      tq_rd_r <= tq_mem[tq_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.asg) asg_pid_r[cmd.idx] <= (lq_cnt_r != '0) ? lq_rd_r : tq_rd_r;
    if (cmd.start) begin
      nl_r <= in_item.new_landings;
      nt_r <= in_item.new_takeoffs;
    end
    if (cmd.load) begin
      out_item.event_kind <= (cmd.pos == '0) ? EV_HEADER :
                             (cmd.pos <= POS_W'(MAX_RUNWAYS)) ? EV_FREE :
                             asg_tk_r[aidx] ? EV_TAKEOFF : EV_LAND;
      out_item.runway <= (cmd.pos == '0) ? 4'd0 :
                         (cmd.pos <= POS_W'(MAX_RUNWAYS)) ? 4'(fidx) : 4'(aidx);
      out_item.plane_id <= (cmd.pos <= POS_W'(MAX_RUNWAYS)) ? 16'd0 : asg_pid_r[aidx];
      out_item.tick <= tick_r;
      out_item.land_wait_sum <= lws_r;
      out_item.takeoff_wait_sum <= tws_r;
      out_item.land_arrivals <= lar_r;
      out_item.takeoff_arrivals <= tar_r;
      out_item.busy_total <= busy_r;
      out_item.all_idle <= idle;
      out_item.overflow <= ovf_r;
      out_item.last <= (ev >> pos_nx) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      land_time_r <= 8'd1;
      take_time_r <= 8'd1;
      servers_r <= 5'd1;
      lq_head_r <= '0;
      tq_head_r <= '0;
      lq_cnt_r <= '0;
      tq_cnt_r <= '0;
      lid_r <= LANDING_BASE;
      tid_r <= '0;
      for (int i = 0; i < MAX_RUNWAYS; i++) timer_r[i] <= '0;
      pend_r <= '0;
      free_m_r <= '0;
      asg_m_r <= '0;
      asg_tk_r <= '0;
      tick_r <= '0;
      lws_r <= '0;
      tws_r <= '0;
      lar_r <= '0;
      tar_r <= '0;
      busy_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_LANDING_TIME: land_time_r <= cfg_wdata;
          CFG_TAKEOFF_TIME: take_time_r <= cfg_wdata;
          CFG_SERVERS: servers_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        ovf_r <= 1'b0;
        asg_m_r <= '0;
        for (int i = 0; i < MAX_RUNWAYS; i++) begin
          free_m_r[i] <= (5'(i) < used) && (timer_r[i] == 8'd0) && pend_r[i];
          if ((5'(i) < used) && (timer_r[i] == 8'd0)) pend_r[i] <= 1'b0;
        end
        lar_r <= lar_r + 32'(in_item.new_landings);
        tar_r <= tar_r + 32'(in_item.new_takeoffs);
        lws_r <= lws_r + 32'(lq_cnt_r);
        tws_r <= tws_r + 32'(tq_cnt_r);
      end
      if (cmd.push_l) begin
        lid_r <= lid_inc;
        if (lq_wr) lq_cnt_r <= lq_cnt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.push_t) begin
        tid_r <= tid_inc;
        if (tq_wr) tq_cnt_r <= tq_cnt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.asg) begin
        if (tcur != 8'd0) begin
          timer_r[cmd.idx] <= tdec;
          busy_r <= busy_r + 32'd1;
          if (tdec == 8'd0) pend_r[cmd.idx] <= 1'b1;
        end else if (lq_cnt_r != '0) begin
          asg_m_r[cmd.idx] <= 1'b1;
          asg_tk_r[cmd.idx] <= 1'b0;
          lq_head_r <= lq_head_r + 1'b1;
          lq_cnt_r <= lq_cnt_r - 1'b1;
          timer_r[cmd.idx] <= ld_land;
          busy_r <= busy_r + 32'd1;
          if (ld_land == 8'd0) pend_r[cmd.idx] <= 1'b1;
        end else if (tq_cnt_r != '0) begin
          asg_m_r[cmd.idx] <= 1'b1;
          asg_tk_r[cmd.idx] <= 1'b1;
          tq_head_r <= tq_head_r + 1'b1;
          tq_cnt_r <= tq_cnt_r - 1'b1;
          timer_r[cmd.idx] <= ld_take;
          busy_r <= busy_r + 32'd1;
          if (ld_take == 8'd0) pend_r[cmd.idx] <= 1'b1;
        end
      end
      if (cmd.load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.done) tick_r <= tick_r + 32'd1;
    end
  end

endmodule
`default_nettype wire
